### rtl/core/shdr_pkg.sv
package shdr_pkg;

  localparam int unsigned OutW = 16;

  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChStar    = 8'h2a;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLowerV  = 8'h76;
  localparam logic [7:0] ChLowerE  = 8'h65;

  localparam logic [3:0] VerLen = 4'd7;
  localparam logic [3:0] ExtLen = 4'd9;

  typedef enum logic [2:0] {
    ModeNormal,
    ModeSlash,
    ModeLine,
    ModeBlock,
    ModeBlockStar,
    ModeHashWs,
    ModeMatch,
    ModeToNl
  } scan_mode_e;

  typedef enum logic {
    KindVersion   = 1'b0,
    KindExtension = 1'b1
  } dir_kind_e;

  function automatic logic [7:0] ver_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h76; // v
      4'd1:    ch = 8'h65; // e
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h73; // s
      4'd4:    ch = 8'h69; // i
      4'd5:    ch = 8'h6f; // o
      4'd6:    ch = 8'h6e; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] ext_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h65; // e
      4'd1:    ch = 8'h78; // x
      4'd2:    ch = 8'h74; // t
      4'd3:    ch = 8'h65; // e
      4'd4:    ch = 8'h6e; // n
      4'd5:    ch = 8'h73; // s
      4'd6:    ch = 8'h69; // i
      4'd7:    ch = 8'h6f; // o
      4'd8:    ch = 8'h6e; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/shader_header_directive_scanner_core.sv
// Shader header directive scanner.
// Input channel (in_valid_i/in_ready_o): one byte of shader source per beat,
// end_of_text_i marks the last byte of a text. Line and block comments are
// skipped; "#version" and "#extension" directives ending in a newline are
// recorded (last version, first extension, body offset and line count).
// Output channel (out_valid_o/out_ready_i): one result beat per text, built
// from the scan state after the last byte.
// Throughput: one byte per cycle while in_ready_o is high; each byte is a single state update.
// The result is registered and shows in the cycle after the last byte is
// accepted. The scan state returns to its initial value on that same edge,
// so the next text may start right away.
// A waiting result does not block input until a second result would need the
// output register: in_ready_o drops only while a result is held, out_ready_i
// is low and the offered byte is the last one of its text.
// Reset (rst_ni low) clears the scan state and drops out_valid_o.
// Texts longer than 2^POS_BITS - 1 bytes set overflow and record nothing
// from that point on.
module shader_header_directive_scanner_core #(
  parameter int unsigned POS_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              char_byte_i,
  input  logic                    end_of_text_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    version_found_o,
  output logic [shdr_pkg::OutW-1:0] version_pos_o,
  output logic                    extension_found_o,
  output logic [shdr_pkg::OutW-1:0] extension_pos_o,
  output logic                    body_found_o,
  output logic [shdr_pkg::OutW-1:0] body_pos_o,
  output logic [shdr_pkg::OutW-1:0] header_lines_o,
  output logic                    overflow_o
);

  localparam logic [POS_BITS:0] PosMax = {1'b0, {POS_BITS{1'b1}}};

  shdr_pkg::scan_mode_e mode_q, mode_d;
  shdr_pkg::dir_kind_e  kind_q, kind_d;
  logic [3:0]           idx_q, idx_d;
  logic [POS_BITS:0]    off_q, off_d;
  logic [POS_BITS-1:0]  nl_q, nl_d;
  logic [POS_BITS-1:0]  hash_q, hash_d;
  logic [POS_BITS-1:0]  ver_pos_q, ver_pos_d;
  logic [POS_BITS-1:0]  ext_pos_q, ext_pos_d;
  logic [POS_BITS-1:0]  body_pos_q, body_pos_d;
  logic [POS_BITS-1:0]  lines_q, lines_d;
  logic                 ver_f_q, ver_f_d;
  logic                 ext_f_q, ext_f_d;
  logic                 body_f_q, body_f_d;
  logic                 ovf_q, ovf_d;

  logic                 out_valid_q;
  logic                 res_ver_f_q, res_ext_f_q, res_body_f_q, res_ovf_q;
  logic [shdr_pkg::OutW-1:0] res_ver_q, res_ext_q, res_body_q, res_lines_q;

  logic in_fire;
  logic last_fire;
  logic is_nl;

  // Only the last byte of a text needs the result register.
  assign in_ready_o = !(out_valid_q && !out_ready_i && end_of_text_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign last_fire  = in_fire && end_of_text_i;
  assign is_nl      = (char_byte_i == shdr_pkg::ChNewline);

  // Per-byte scan step; a byte that breaks a match or follows a lone slash
  // is run through the normal-mode decode a second time.
  always_comb begin
    logic       rescan;
    logic [3:0] len;
    logic [7:0] want;
    mode_d     = mode_q;
    kind_d     = kind_q;
    idx_d      = idx_q;
    off_d      = off_q;
    nl_d       = nl_q;
    hash_d     = hash_q;
    ver_pos_d  = ver_pos_q;
    ext_pos_d  = ext_pos_q;
    body_pos_d = body_pos_q;
    lines_d    = lines_q;
    ver_f_d    = ver_f_q;
    ext_f_d    = ext_f_q;
    body_f_d   = body_f_q;
    ovf_d      = ovf_q || (off_q >= PosMax);
    rescan     = 1'b0;
    len        = (kind_q == shdr_pkg::KindExtension) ? shdr_pkg::ExtLen : shdr_pkg::VerLen;
    want       = (kind_q == shdr_pkg::KindExtension) ? shdr_pkg::ext_char(idx_q)
                                                     : shdr_pkg::ver_char(idx_q);

    if (is_nl && (nl_q != {POS_BITS{1'b1}})) begin
      nl_d = nl_q + 1'b1;
    end

    case (mode_q)
      shdr_pkg::ModeNormal: begin
        rescan = 1'b1;
      end
      shdr_pkg::ModeSlash: begin
        if (char_byte_i == shdr_pkg::ChSlash) begin
          mode_d = shdr_pkg::ModeLine;
        end else if (char_byte_i == shdr_pkg::ChStar) begin
          mode_d = shdr_pkg::ModeBlock;
        end else begin
          rescan = 1'b1;
        end
      end
      shdr_pkg::ModeLine: begin
        if (is_nl) mode_d = shdr_pkg::ModeNormal;
      end
      shdr_pkg::ModeBlock: begin
        if (char_byte_i == shdr_pkg::ChStar) mode_d = shdr_pkg::ModeBlockStar;
      end
      shdr_pkg::ModeBlockStar: begin
        if (char_byte_i == shdr_pkg::ChSlash) begin
          mode_d = shdr_pkg::ModeNormal;
        end else if (char_byte_i != shdr_pkg::ChStar) begin
          mode_d = shdr_pkg::ModeBlock;
        end
      end
      shdr_pkg::ModeHashWs: begin
        if (char_byte_i == shdr_pkg::ChLowerV) begin
          kind_d = shdr_pkg::KindVersion;
          idx_d  = 4'd1;
          mode_d = shdr_pkg::ModeMatch;
        end else if (char_byte_i == shdr_pkg::ChLowerE) begin
          kind_d = shdr_pkg::KindExtension;
          idx_d  = 4'd1;
          mode_d = shdr_pkg::ModeMatch;
        end else if (char_byte_i != shdr_pkg::ChSpace && char_byte_i != shdr_pkg::ChTab) begin
          mode_d = shdr_pkg::ModeNormal;
        end
      end
      shdr_pkg::ModeMatch: begin
        if (idx_q < len && char_byte_i == want) begin
          idx_d = idx_q + 4'd1;
          if (idx_d >= len) mode_d = shdr_pkg::ModeToNl;
        end else begin
          idx_d  = 4'd0;
          rescan = 1'b1;
        end
      end
      shdr_pkg::ModeToNl: begin
        if (is_nl) begin
          mode_d = shdr_pkg::ModeNormal;
          idx_d  = 4'd0;
          if (!ovf_d) begin
            if (kind_q == shdr_pkg::KindVersion) begin
              ver_pos_d = hash_q;
              ver_f_d   = 1'b1;
            end else if (!ext_f_q) begin
              ext_pos_d = hash_q;
              ext_f_d   = 1'b1;
            end
            body_pos_d = off_q[POS_BITS-1:0] + 1'b1;
            lines_d    = nl_d;
            body_f_d   = 1'b1;
          end
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    if (rescan) begin
      if (char_byte_i == shdr_pkg::ChSlash) begin
        mode_d = shdr_pkg::ModeSlash;
      end else if (char_byte_i == shdr_pkg::ChHash) begin
        hash_d = off_q[POS_BITS-1:0];
        mode_d = shdr_pkg::ModeHashWs;
      end else begin
        mode_d = shdr_pkg::ModeNormal;
      end
    end

    if (off_q <= PosMax) off_d = off_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= shdr_pkg::ModeNormal;
      kind_q     <= shdr_pkg::KindVersion;
      idx_q      <= '0;
      off_q      <= '0;
      nl_q       <= '0;
      hash_q     <= '0;
      ver_pos_q  <= '0;
      ext_pos_q  <= '0;
      body_pos_q <= '0;
      lines_q    <= '0;
      ver_f_q    <= 1'b0;
      ext_f_q    <= 1'b0;
      body_f_q   <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (last_fire) begin
      // result leaves with this beat; start the next text clean
      mode_q     <= shdr_pkg::ModeNormal;
      kind_q     <= shdr_pkg::KindVersion;
      idx_q      <= '0;
      off_q      <= '0;
      nl_q       <= '0;
      hash_q     <= '0;
      ver_pos_q  <= '0;
      ext_pos_q  <= '0;
      body_pos_q <= '0;
      lines_q    <= '0;
      ver_f_q    <= 1'b0;
      ext_f_q    <= 1'b0;
      body_f_q   <= 1'b0;
      ovf_q      <= 1'b0;
    end else if (in_fire) begin
      mode_q     <= mode_d;
      kind_q     <= kind_d;
      idx_q      <= idx_d;
      off_q      <= off_d;
      nl_q       <= nl_d;
      hash_q     <= hash_d;
      ver_pos_q  <= ver_pos_d;
      ext_pos_q  <= ext_pos_d;
      body_pos_q <= body_pos_d;
      lines_q    <= lines_d;
      ver_f_q    <= ver_f_d;
      ext_f_q    <= ext_f_d;
      body_f_q   <= body_f_d;
      ovf_q      <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_fire) begin
      res_ver_f_q  <= ver_f_d;
      res_ext_f_q  <= ext_f_d;
      res_body_f_q <= body_f_d;
      res_ovf_q    <= ovf_d;
      res_ver_q    <= ver_f_d  ? shdr_pkg::OutW'(ver_pos_d)  : '0;
      res_ext_q    <= ext_f_d  ? shdr_pkg::OutW'(ext_pos_d)  : '0;
      res_body_q   <= body_f_d ? shdr_pkg::OutW'(body_pos_d) : '0;
      res_lines_q  <= body_f_d ? shdr_pkg::OutW'(lines_d)    : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign version_found_o   = res_ver_f_q;
  assign version_pos_o     = res_ver_q;
  assign extension_found_o = res_ext_f_q;
  assign extension_pos_o   = res_ext_q;
  assign body_found_o      = res_body_f_q;
  assign body_pos_o        = res_body_q;
  assign header_lines_o    = res_lines_q;
  assign overflow_o        = res_ovf_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> out_valid_o)
    else $error("no result after last byte");

  a_last_clears_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_fire |=> (mode_q == shdr_pkg::ModeNormal) && (off_q == '0) && !ovf_q)
    else $error("scan state not cleared after last byte");

  a_found_needs_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ver_f_q || ext_f_q) |-> body_f_q)
    else $error("directive recorded without body position");

  a_match_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == shdr_pkg::ModeMatch) |-> (idx_q != 4'd0) && (idx_q < 4'd9))
    else $error("match index out of range");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q && !last_fire) |=> ovf_q)
    else $error("overflow flag dropped mid-text");

endmodule
